>>> src/ssa_pkg.sv
// Shared types and constants of the station signal aggregator.
// Used by ssa_div, ssa_dp, ssa_ctrl and the top level; depends on nothing.
package ssa_pkg;

  localparam int unsigned TableEntriesDef = 32;

  localparam int unsigned MacW   = 48;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned SumW   = 26;
  localparam int unsigned LvlW   = 10;
  localparam int unsigned OutLvlW = 9;
  localparam int unsigned HoldW  = 8;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic signed [LvlW-1:0] MaxFloor = -10'sd255;

  typedef struct packed {
    logic [MacW-1:0]        mac;
    logic [TimeW-1:0]       first;
    logic [CountW-1:0]      count;
    logic signed [SumW-1:0] sum;
    logic signed [LvlW-1:0] vmax;
    logic signed [LvlW-1:0] vmin;
  } entry_t;

  typedef struct packed {
    logic [MacW-1:0]           mac;
    logic signed [OutLvlW-1:0] avg;
    logic signed [OutLvlW-1:0] vmax;
    logic signed [OutLvlW-1:0] vmin;
  } report_t;

  typedef enum logic [3:0] {
    StIdle, StSrchRd, StSrchCmp, StAppend, StSweepInit, StSweepRd,
    StSweepEval, StDivWait, StPush, StEnd, StFlush
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic srch_init;
    logic rd;
    logic hit_wr;
    logic idx_inc;
    logic app_wr;
    logic sw_init;
    logic keep_wr;
    logic div_start;
    logic push;
    logic end_cnt;
    logic flush;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame;
    logic cnt_zero;
    logic match;
    logic last_idx;
    logic old;
    logic div_done;
    logic pend_v;
    logic out_free;
  } stat_t;

endpackage

>>> src/ssa_div.sv
// Restoring divider, one quotient bit per cycle, signed sum by count.
// Depends on ssa_pkg.
module ssa_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ssa_pkg::SumW-1:0]    sum_i,
  input  logic [ssa_pkg::CountW-1:0]         count_i,
  output logic                               done_o,
  output logic signed [ssa_pkg::OutLvlW-1:0] quot_o
);
  import ssa_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic              busy_q, busy_d, done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CountW:0]   rem_q, rem_d;
  logic [SumW-1:0]   quo_q, quo_d;
  logic [CountW-1:0] den_q, den_d;
  logic              neg_q, neg_d;
  logic [CountW:0]   rem_sh;
  logic [SumW-1:0]   neg_quo;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[CountW-1:0], quo_q[SumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(SumW);
      rem_d  = '0;
      quo_d  = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
      den_d  = count_i;
      neg_d  = sum_i[SumW-1];
    end else if (busy_q) begin
      // Zero count divides to zero.
      if (den_q == '0) begin
        quo_d  = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          quo_d = {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[SumW-2:0], 1'b0};
        end
        step_d = step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign neg_quo = -quo_q;
  assign done_o  = done_q;
  assign quot_o  = neg_q ? neg_quo[OutLvlW-1:0] : quo_q[OutLvlW-1:0];

endmodule

>>> src/ssa_dp.sv
// Datapath: station table memory, search and sweep pointers, report and output words.
// Depends on ssa_pkg and ssa_div.
module ssa_dp #(
  parameter int unsigned TableEntries = ssa_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssa_pkg::cmd_t                 cmd_i,
  output ssa_pkg::stat_t                stat_o,
  input  logic                          cfg_we_i,
  input  logic [ssa_pkg::HoldW-1:0]     cfg_wdata_i,
  input  logic                          in_frame_i,
  input  logic [ssa_pkg::MacW-1:0]      in_mac_i,
  input  logic [7:0]                    in_byte_i,
  input  logic [ssa_pkg::TimeW-1:0]     in_now_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output ssa_pkg::report_t              out_word_o,
  output logic                          out_last_o
);
  import ssa_pkg::*;

  localparam int unsigned AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned IdxW  = $clog2(TableEntries + 1);

  entry_t            mem_q [TableEntries];
  entry_t            rd_q, wr_data, upd;
  logic [AddrW-1:0]  wr_addr;
  logic              wr_en;

  logic [HoldW-1:0]  hold_q;
  logic              frame_q;
  logic [MacW-1:0]   mac_q;
  logic signed [LvlW-1:0] lvl_q;
  logic [TimeW-1:0]  now_q;
  logic [IdxW-1:0]   idx_q, kept_q, cnt_q;
  report_t           rep_q, pend_q, out_q;
  logic              pend_v_q, out_v_q, out_last_q;
  logic [TimeW-1:0]  age;
  logic              div_done;
  logic signed [OutLvlW-1:0] div_q;
  logic              out_free;

  // Add the held sample to the entry just read, unless its count is saturated.
  always_comb begin
    upd = rd_q;
    if (rd_q.count != CountMax) begin
      upd.count = rd_q.count + CountW'(1);
      upd.sum   = rd_q.sum + SumW'(lvl_q);
      if (rd_q.vmax < lvl_q) upd.vmax = lvl_q;
      if (rd_q.vmin > lvl_q) upd.vmin = lvl_q;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[AddrW-1:0];
    wr_data = upd;
    if (cmd_i.hit_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.app_wr && (cnt_q < IdxW'(TableEntries))) begin
      wr_en = 1'b1;
      wr_addr = cnt_q[AddrW-1:0];
      wr_data.mac   = mac_q;
      wr_data.first = now_q;
      wr_data.count = CountW'(1);
      wr_data.sum   = SumW'(lvl_q);
      wr_data.vmax  = (lvl_q > MaxFloor) ? lvl_q : MaxFloor;
      wr_data.vmin  = lvl_q;
    end else if (cmd_i.keep_wr) begin
      wr_en = 1'b1;
      wr_addr = kept_q[AddrW-1:0];
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd) rd_q <= mem_q[idx_q[AddrW-1:0]];
  end

  ssa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .sum_i   (rd_q.sum),
    .count_i (rd_q.count),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_q <= in_frame_i;
      mac_q   <= in_mac_i;
      lvl_q   <= {2'b11, in_byte_i};
      now_q   <= in_now_i;
    end
    if (cmd_i.div_start) begin
      rep_q.mac  <= rd_q.mac;
      rep_q.vmax <= rd_q.vmax[OutLvlW-1:0];
      rep_q.vmin <= rd_q.vmin[OutLvlW-1:0];
    end
    if (div_done) rep_q.avg <= div_q;
    if (cmd_i.push) pend_q <= rep_q;
    if ((cmd_i.push && pend_v_q) || (cmd_i.flush && pend_v_q)) out_q <= pend_q;
  end

  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q     <= HoldW'(1);
      idx_q      <= '0;
      kept_q     <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) hold_q <= cfg_wdata_i;
      if (cmd_i.srch_init || cmd_i.sw_init) idx_q <= '0;
      else if (cmd_i.idx_inc || cmd_i.keep_wr) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.sw_init) kept_q <= '0;
      else if (cmd_i.keep_wr) kept_q <= kept_q + IdxW'(1);
      if (cmd_i.app_wr && (cnt_q < IdxW'(TableEntries))) cnt_q <= cnt_q + IdxW'(1);
      else if (cmd_i.end_cnt) cnt_q <= kept_q;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (cmd_i.push) begin
        pend_v_q <= 1'b1;
        if (pend_v_q) begin
          out_v_q    <= 1'b1;
          out_last_q <= 1'b0;
        end
      end else if (cmd_i.flush && pend_v_q) begin
        pend_v_q   <= 1'b0;
        out_v_q    <= 1'b1;
        out_last_q <= 1'b1;
      end
    end
  end

  assign age = now_q - rd_q.first;

  assign stat_o.frame    = frame_q;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.match    = (rd_q.mac == mac_q);
  assign stat_o.last_idx = ((idx_q + IdxW'(1)) == cnt_q);
  assign stat_o.old      = (age >= TimeW'(hold_q));
  assign stat_o.div_done = div_done;
  assign stat_o.pend_v   = pend_v_q;
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;
  assign out_last_o  = out_last_q;

endmodule

>>> src/ssa_ctrl.sv
// Controller state machine: sequences search, append, sweep, report and flush.
// Depends on ssa_pkg.
module ssa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssa_pkg::stat_t stat_i,
  output ssa_pkg::cmd_t  cmd_o
);
  import ssa_pkg::*;

  state_e state_q, state_d;
  logic   can_push;

  assign can_push = !stat_i.pend_v || stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StSrchRd;
      StSrchRd: begin
        if (!stat_i.frame) state_d = StSweepInit;
        else if (stat_i.cnt_zero) state_d = StAppend;
      end
      StSrchCmp: begin
        if (stat_i.match) state_d = StSweepInit;
        else if (stat_i.last_idx) state_d = StAppend;
        else state_d = StSrchRd;
      end
      StAppend: state_d = StSweepInit;
      StSweepInit: state_d = stat_i.cnt_zero ? StFlush : StSweepRd;
      StSweepRd: state_d = StSweepEval;
      StSweepEval: begin
        if (stat_i.old) state_d = StDivWait;
        else if (stat_i.last_idx) state_d = StEnd;
        else state_d = StSweepRd;
      end
      StDivWait: if (stat_i.div_done) state_d = StPush;
      StPush: begin
        if (can_push) state_d = stat_i.last_idx ? StEnd : StSweepRd;
      end
      StEnd: state_d = StFlush;
      StFlush: if (can_push) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    // Search goes on to compare only when there is a frame and a table to look through.
    if (state_q == StSrchRd && stat_i.frame && !stat_i.cnt_zero) state_d = StSrchCmp;
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o     = 1'b1;
        cmd_o.load     = in_valid_i;
        cmd_o.srch_init = in_valid_i;
      end
      StSrchRd: cmd_o.rd = 1'b1;
      StSrchCmp: begin
        cmd_o.hit_wr  = stat_i.match;
        cmd_o.idx_inc = !stat_i.match;
      end
      StAppend: cmd_o.app_wr = 1'b1;
      StSweepInit: cmd_o.sw_init = 1'b1;
      StSweepRd: cmd_o.rd = 1'b1;
      StSweepEval: begin
        cmd_o.div_start = stat_i.old;
        cmd_o.keep_wr   = !stat_i.old;
      end
      StDivWait: ;
      StPush: begin
        cmd_o.push    = can_push;
        cmd_o.idx_inc = can_push;
      end
      StEnd: cmd_o.end_cnt = 1'b1;
      StFlush: cmd_o.flush = can_push;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

endmodule

>>> src/station_signal_aggregator.sv
// Top level of the station signal aggregator.
// Depends on ssa_pkg, ssa_ctrl, ssa_dp (and through it ssa_div).
//
// Use:
//   Slave stream: one word per received frame. tuser = frame_valid (1 = the
//   word carries a sample, 0 = sweep aged stations only). tdata carries the
//   address, the raw signal byte and the time in seconds.
//   Master stream: one word per reported station; tlast marks the last
//   report caused by one input word.
//   Config: cfg_we_i writes hold_seconds from cfg_wdata_i; write only while
//   the block is idle (s_axis_tready_o high, no report pending).
// Flow:
//   One input word at a time. The search reads and compares table entries
//   in order up to the match, the sweep reads and evaluates every live
//   entry, and every report waits for the single bit-serial divider. The
//   table is a single-port-write, single-port-read memory with registered
//   read data.
// Reset: empties the table (entry count to zero, no clearing pass) and sets
//   hold_seconds to 1.
// Stall: reports wait in a pending word and the output register; once both
//   are full and tready is low, the sweep stops at the next report.
module station_signal_aggregator #(
  parameter int unsigned TABLE_ENTRIES = ssa_pkg::TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [47:0] station_mac, [55:48] signal_byte, [87:56] now_seconds
  input  logic [87:0] s_axis_tdata_i,
  // [0] frame_valid
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [47:0] reported_mac, [56:48] average_level, [65:57] strongest_level,
  // [74:66] weakest_level, [79:75] zero
  output logic [79:0] m_axis_tdata_o,
  // last_of_run
  output logic        m_axis_tlast_o
);
  import ssa_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  report_t word;

  ssa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssa_dp #(
    .TableEntries (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_frame_i  (s_axis_tuser_i),
    .in_mac_i    (s_axis_tdata_i[47:0]),
    .in_byte_i   (s_axis_tdata_i[55:48]),
    .in_now_i    (s_axis_tdata_i[87:56]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_word_o  (word),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack the report lowest field first.
  assign m_axis_tdata_o = {5'b0, word.vmin, word.vmax, word.avg, word.mac};

endmodule

>>> src/ssa_checker.sv
// Port-level checks of the station signal aggregator, bound to the top level.
// Depends on station_signal_aggregator.
module ssa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // Hold a stalled report word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled report word changed");

  // One word at a time: busy right after an accept.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // When idle, any waiting report closes its run.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("idle with an unfinished run");

endmodule

bind station_signal_aggregator ssa_checker u_ssa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> sim/ssa_checker.sv
// Checker of the station signal aggregator: watches both streams and the config port,
// predicts reports with its own station table and compares them. Depends on ssa_pkg.
`timescale 1ns / 100ps
module ssa_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [79:0] m_axis_tdata_o,
  input  logic        m_axis_tlast_o,
  output int          fail_count,
  output int          pending_reports,
  output int          report_total
);
  import ssa_pkg::*;

  localparam int Slots = 32;

  typedef struct {
    logic [47:0] mac;
    logic [31:0] first;
    int          count;
    int          sum;
    int          vmax;
    int          vmin;
  } station_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [8:0]  avg;
    logic [8:0]  vmax;
    logic [8:0]  vmin;
    logic        last;
  } report_word_t;

  station_t     stations[Slots];
  int           live;
  logic [7:0]   hold;
  report_word_t report_queue[$];

  assign pending_reports = report_queue.size();

  // Fold a valid frame into the table, then sweep aged stations out in table order.
  task automatic age_and_report(input logic valid, input logic [47:0] mac,
                                input logic [7:0] sig, input logic [31:0] now);
    int lvl, hit, kept, first_rep;
    report_word_t r;
    lvl = int'(sig) - 256;
    kept = 0;
    first_rep = report_queue.size();
    if (valid) begin
      hit = -1;
      for (int i = 0; i < live; i++)
        if (hit < 0 && stations[i].mac == mac) hit = i;
      if (hit < 0 && live < Slots) begin
        hit = live;
        stations[hit].mac = mac;
        stations[hit].first = now;
        stations[hit].count = 0;
        stations[hit].sum = 0;
        stations[hit].vmax = -255;
        stations[hit].vmin = 255;
        live++;
      end
      if (hit >= 0 && stations[hit].count < 65535) begin
        stations[hit].count++;
        stations[hit].sum += lvl;
        if (stations[hit].vmax < lvl) stations[hit].vmax = lvl;
        if (stations[hit].vmin > lvl) stations[hit].vmin = lvl;
      end
    end
    for (int i = 0; i < live; i++) begin
      if (32'(now - stations[i].first) >= {24'd0, hold}) begin
        r.mac = stations[i].mac;
        r.avg = 9'((stations[i].count != 0) ? stations[i].sum / stations[i].count : 0);
        r.vmax = 9'(stations[i].vmax);
        r.vmin = 9'(stations[i].vmin);
        r.last = 1'b0;
        report_queue.push_back(r);
      end else begin
        stations[kept] = stations[i];
        kept++;
      end
    end
    live = kept;
    if (report_queue.size() > first_rep) report_queue[$].last = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    report_total = 0;
    live = 0;
    hold = 8'd1;
  end

  always @(posedge clk_i) begin
    report_word_t seen, want;
    if (rst_ni) begin
      if (cfg_we_i) hold <= cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_o)
        age_and_report(s_axis_tuser_i, s_axis_tdata_i[47:0], s_axis_tdata_i[55:48],
                       s_axis_tdata_i[87:56]);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen = {m_axis_tdata_o[47:0], m_axis_tdata_o[56:48], m_axis_tdata_o[65:57],
                m_axis_tdata_o[74:66], m_axis_tlast_o};
        report_total++;
        if (report_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected report word %h", seen);
        end else begin
          want = report_queue.pop_front();
          if (seen != want || m_axis_tdata_o[79:75] != 5'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"report mismatch: mac exp %h got %h, avg %h/%h, max %h/%h,",
                        " min %h/%h, last %b/%b"},
                       want.mac, seen.mac, want.avg, seen.avg, want.vmax, seen.vmax,
                       want.vmin, seen.vmin, want.last, seen.last);
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_station_signal_aggregator.sv
// Testbench top of the station signal aggregator: drives frames, hold settings and
// back-pressure. Depends on ssa_pkg, the block under src and ssa_checker.
`timescale 1ns / 100ps
module tb_station_signal_aggregator;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [87:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int fail_count, pending_reports, report_total;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold_off = 1'b0;
  int frames_sent = 0;

  // Small pool of addresses so frames hit existing entries; a few differ in one byte.
  logic [47:0] mac_pool[40];
  logic [31:0] clock_s = 32'd1000;

  station_signal_aggregator dut (.*);

  ssa_scoreboard u_checker (.*);

  initial forever #1 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    if (recv_hold_off) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one word; hold tvalid until accepted, idle at random first.
  task automatic send_frame(input logic valid, input logic [47:0] mac,
                            input logic [7:0] sig, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= valid;
    s_axis_tdata_i <= {now, sig, mac};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    frames_sent++;
  endtask

  // Drain, give the block time to finish its sweep, then write hold_seconds.
  task automatic set_hold(input logic [7:0] value);
    while (pending_reports != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int frames);
    int pick;
    for (int n = 0; n < frames; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) clock_s = clock_s + $urandom_range(1);
      else if (pick < 63) clock_s = $urandom;
      if (pick < 8)
        send_frame(1'b0, 48'({$urandom, $urandom}), 8'($urandom), clock_s);
      else if (pick < 14)
        send_frame(1'b1, 48'({$urandom, $urandom}), 8'($urandom), clock_s);
      else
        send_frame(1'b1, mac_pool[$urandom_range(39)], 8'($urandom), clock_s);
    end
  endtask

  initial begin
    for (int k = 0; k < 40; k++)
      mac_pool[k] = (k < 4) ? 48'h00AB_CD00_0000 | (48'(k) << 8 * k)
                            : 48'({$urandom, $urandom});
    mac_pool[4] = '0;
    mac_pool[5] = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes of levels, floor of strongest, sweep-only words, wrap of time.
    send_frame(1'b1, mac_pool[4], 8'h00, 32'd10);
    send_frame(1'b1, mac_pool[4], 8'h00, 32'd10);
    send_frame(1'b1, mac_pool[5], 8'hFF, 32'd10);
    send_frame(1'b1, mac_pool[0], 8'h80, 32'd10);
    send_frame(1'b1, mac_pool[1], 8'h01, 32'd10);
    send_frame(1'b0, mac_pool[0], 8'h55, 32'd11);
    send_frame(1'b1, mac_pool[2], 8'hAA, 32'hFFFF_FFFF);
    send_frame(1'b0, '0, 8'h00, 32'd0);
    // Table full: 33 distinct stations in the same second, then sweep.
    set_hold(8'd255);
    for (int k = 0; k < 33; k++)
      send_frame(1'b1, {16'hBEEF, 32'(k)}, 8'(k * 7), 32'd500);
    send_frame(1'b1, 48'hBEEF_0000_0003, 8'hFF, 32'd600);
    send_frame(1'b0, '0, 8'h00, 32'd755);
    // Hold of zero: reported in the same step.
    set_hold(8'd0);
    send_frame(1'b1, mac_pool[3], 8'h7F, 32'd900);
    send_frame(1'b0, '0, 8'h00, 32'd900);

    set_hold(8'd2);
    send_idle_pct = 21; recv_idle_pct = 47;
    random_phase(170);
    // Long receiver hold-off while frames keep coming.
    recv_hold_off = 1'b1;
    fork
      begin
        int stall;
        for (stall = 0; stall < 3000; stall++) @(posedge clk_i);
        recv_hold_off = 1'b0;
      end
      random_phase(30);
    join

    set_hold(8'd1);
    send_idle_pct = 47; recv_idle_pct = 21;
    random_phase(150);
    set_hold(8'd3);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(150);
    send_frame(1'b0, '0, 8'h00, clock_s + 32'd1000);

    while (pending_reports != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d frames over hold settings 0, 1, 2, 3, 255; %0d reports compared.",
             frames_sent, report_total);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
